### rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the nearest point search unit.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int MAX_POINTS = 256;
  localparam int COORD_BITS = 16;

  localparam int IDX_W     = $clog2(MAX_POINTS);
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W    = COORD_BITS + 1;
  localparam int MAG_W     = COORD_BITS;
  localparam int SQ_W      = 2 * COORD_BITS;
  localparam int SUM_W     = SQ_W + 2;
  localparam int OUT_IDX_W = 8;
  localparam int DIST_W    = 34;

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_FIND  = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    logic [1:0]                   req_type;
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic signed [COORD_BITS-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] point_index;
    logic [DIST_W-1:0]    best_dist_sq;
    logic [1:0]           status;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic do_add;
    logic do_clear;
    logic do_nop;
    logic find_empty;
    logic find_start;
    logic scan_issue;
    logic find_done;
  } nps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic pipe_busy;
  } nps_stat_t;

endpackage

### rtl/nps_ctrl.sv
// ----------------------------------------------------------------------------
// nps_ctrl
// Request decode and scan sequencing for the nearest point search unit.
// ----------------------------------------------------------------------------
module nps_ctrl
  import nps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] req_type,
  input  nps_stat_t  stat,
  output nps_cmd_t   cmd,
  output logic       busy
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (req_type)
            REQ_ADD:   cmd.do_add   = 1'b1;
            REQ_CLEAR: cmd.do_clear = 1'b1;
            REQ_FIND: begin
              if (stat.count_zero) begin
                cmd.find_empty = 1'b1;
              end else begin
                cmd.find_start = 1'b1;
                state_nxt      = ST_SCAN;
              end
            end
            default:   cmd.do_nop   = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait for the last compare to retire
        if (!stat.pipe_busy) begin
          cmd.find_done = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### rtl/nps_datapath.sv
// ----------------------------------------------------------------------------
// nps_datapath
// Point store, fill count, distance pipeline, best tracking and result reg.
// ----------------------------------------------------------------------------
module nps_datapath
  import nps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  nps_cmd_t  cmd,
  output nps_stat_t stat,
  output logic      out_strobe,
  output out_item_t out_item
);

  point_t mem [MAX_POINTS];

  logic [CNT_W-1:0] count_r;
  logic [IDX_W-1:0] scan_addr_r;
  point_t           query_r;
  logic             full;

  // stage 1: store read
  logic             s1_valid_r;
  logic [IDX_W-1:0] s1_idx_r;
  point_t           s1_pt_r;
  // stage 2: squared differences
  logic             s2_valid_r;
  logic [IDX_W-1:0] s2_idx_r;
  logic [SQ_W-1:0]  s2_sqx_r;
  logic [SQ_W-1:0]  s2_sqy_r;
  logic [SQ_W-1:0]  s2_sqz_r;
  // stage 3: distance sum
  logic             s3_valid_r;
  logic [IDX_W-1:0] s3_idx_r;
  logic [SUM_W-1:0] s3_sum_r;
  // running best
  logic             best_have_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [SUM_W-1:0] best_sum_r;

  logic      out_strobe_r;
  out_item_t out_item_r;
  out_item_t out_item_nxt;
  point_t    in_pt;

  function automatic logic [SQ_W-1:0] sq_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic signed [DIFF_W-1:0] d;
    logic [DIFF_W-1:0]        m;
    logic [MAG_W-1:0]         mag;
    d   = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    m   = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    mag = m[MAG_W-1:0];
    return SQ_W'(mag) * SQ_W'(mag);
  endfunction

  assign in_pt = '{x: in_item.pos_x, y: in_item.pos_y, z: in_item.pos_z};
  assign full  = (count_r == CNT_W'(MAX_POINTS));

  assign stat.count_zero = (count_r == '0);
  assign stat.scan_last  = (CNT_W'(scan_addr_r) == count_r - CNT_W'(1));
  assign stat.pipe_busy  = s1_valid_r | s2_valid_r | s3_valid_r;

  // store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_add && !full) begin
      mem[count_r[IDX_W-1:0]] <= in_pt;
    end
    if (cmd.scan_issue) begin
      s1_pt_r <= mem[scan_addr_r];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      scan_addr_r  <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      best_have_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cmd.do_add && !full) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.do_clear) begin
        count_r <= '0;
      end
      if (cmd.find_start) begin
        scan_addr_r <= '0;
      end else if (cmd.scan_issue) begin
        scan_addr_r <= scan_addr_r + IDX_W'(1);
      end
      s1_valid_r <= cmd.scan_issue;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      if (cmd.find_start) begin
        best_have_r <= 1'b0;
      end else if (s3_valid_r) begin
        best_have_r <= 1'b1;
      end
      out_strobe_r <= cmd.do_add | cmd.do_clear | cmd.do_nop |
                      cmd.find_empty | cmd.find_done;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    if (cmd.find_start) begin
      query_r <= in_pt;
    end
    s1_idx_r <= scan_addr_r;
    s2_idx_r <= s1_idx_r;
    s2_sqx_r <= sq_diff(s1_pt_r.x, query_r.x);
    s2_sqy_r <= sq_diff(s1_pt_r.y, query_r.y);
    s2_sqz_r <= sq_diff(s1_pt_r.z, query_r.z);
    s3_idx_r <= s2_idx_r;
    s3_sum_r <= SUM_W'(s2_sqx_r) + SUM_W'(s2_sqy_r) + SUM_W'(s2_sqz_r);
    // strict less-than keeps the lowest index on ties
    if (s3_valid_r && (!best_have_r || (s3_sum_r < best_sum_r))) begin
      best_idx_r <= s3_idx_r;
      best_sum_r <= s3_sum_r;
    end
  end

  always_comb begin
    out_item_nxt = '0;
    if (cmd.do_add) begin
      if (full) begin
        out_item_nxt.status = STATUS_FULL;
      end else begin
        out_item_nxt.point_index = OUT_IDX_W'(count_r);
      end
    end else if (cmd.find_empty) begin
      out_item_nxt.status = STATUS_EMPTY;
    end else if (cmd.find_done) begin
      out_item_nxt.point_index  = OUT_IDX_W'(best_idx_r);
      out_item_nxt.best_dist_sq = DIST_W'(best_sum_r);
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table size");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_issue |-> !stat.count_zero)
    else $error("scan issued on empty table");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (CNT_W'(s3_idx_r) < count_r))
    else $error("compare on entry past fill count");

  a_add_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_add && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted add did not bump count");

endmodule

### rtl/nearest_point_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_point_search_unit
// Brute-force nearest neighbor search over a table of 3D points.
// ----------------------------------------------------------------------------
// Usage: a request transfers at a rising edge with start high and busy low.
// Add, clear and unused request codes need no scan: the result strobe
// rises on the next cycle and busy never goes high, so such requests can be
// issued back to back. A find on a non-empty table holds busy while the
// scan runs over the stored points: the single store read port delivers
// one point per cycle to the distance/compare pipeline, and the answer
// strobes out in the first cycle with busy low again. A find on an empty
// table answers like an add. Every result sits on out_item for exactly one
// cycle with out_strobe high; the receiver cannot stall it, so it must take
// each transfer as it comes. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module nearest_point_search_unit
  import nps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  nps_cmd_t  cmd;
  nps_stat_t stat;

  // sequencer: decodes requests and steps the scan
  nps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_item.req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // store, distance pipeline and result register
  nps_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
